// ===== rtl/bgzf_pkg.sv =====
`default_nettype none

package bgzf_pkg;

  localparam int unsigned SpanW  = 17;
  localparam int unsigned XlenW  = 16;
  localparam int unsigned SizeW  = 32;

  localparam logic [7:0] GzipId1   = 8'h1f;
  localparam logic [7:0] GzipId2   = 8'h8b;
  localparam logic [7:0] BcSi1     = 8'h42;
  localparam logic [7:0] BcSi2     = 8'h43;
  localparam logic [15:0] BcSlen   = 16'd2;
  localparam int unsigned FextraBit = 2;
  localparam int unsigned HdrLen    = 12;
  localparam int unsigned Overhead  = 20;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_VERDICT = 2'd1,
    KIND_TRAILER = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOTBGZF = 2'd1,
    ST_CORRUPT = 2'd2
  } status_e;

  typedef struct packed {
    kind_e              kind;
    logic [7:0]         payload_byte;
    status_e            status;
    logic [SpanW-1:0]   block_size;
    logic [XlenW-1:0]   extra_len;
    logic [SpanW-1:0]   payload_len;
    logic [SizeW-1:0]   uncompressed_size;
    logic               last;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/bgzf_out_stage.sv =====
`default_nettype none

module bgzf_out_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire bgzf_pkg::result_t res_i,
  output logic                   ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output bgzf_pkg::result_t      res_o
);

  logic              valid_q;
  bgzf_pkg::result_t data_q;

  // The stage can take a new result when empty or when its current one leaves.
  assign ready_o     = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign res_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q <= res_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bgzf_block_deframer_unit.sv =====
`default_nettype none

// BGZF block deframer: takes one byte of the compressed stream per clock and,
// for each block candidate marked by block_start_i, yields a header verdict,
// the raw deflate payload bytes and finally the trailer's uncompressed size.
// The whole parse of a byte is done in the cycle it is accepted, so a byte can
// be accepted on every clock and its result, if any, is shown in the output
// register on the following cycle. The input is held off only while that
// output register holds a result that the sink has not taken. Header bytes
// that pass, extra-field bytes other than the last, the CRC bytes and the
// first three bytes of the size word, and bytes while idle give no result.
// There is no start-up sweep: the block is ready straight after reset.
module bgzf_block_deframer_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        block_start_i,
  input  wire logic [16:0] span_bytes_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       kind_o,
  output logic [7:0]       payload_byte_o,
  output logic [1:0]       status_o,
  output logic [16:0]      block_size_o,
  output logic [15:0]      extra_len_o,
  output logic [16:0]      payload_len_o,
  output logic [31:0]      uncompressed_size_o,
  output logic             last_o
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_EXTRA,
    PH_BODY
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [16:0] bp_q, bp_d;
  logic [16:0] span_q, span_d;
  logic [15:0] xl_q, xl_d;
  logic [15:0] sfo_q, sfo_d;
  logic [31:0] sb_q, sb_d;
  logic [16:0] fbs_q, fbs_d;
  logic        found_q, found_d;
  logic [31:0] acc_q, acc_d;

  bgzf_pkg::result_t res, res_out;
  logic              res_valid;
  logic              in_accept;
  logic              stage_ready;

  logic [16:0] bp_inc;
  logic [15:0] xl_new;
  logic [16:0] ext_pos;
  logic [16:0] off17;
  logic [16:0] rel;
  logic [31:0] sb_new;
  logic [17:0] skip_to;
  logic [16:0] bsize;
  logic [17:0] pos18;
  logic [17:0] bs18;
  logic [17:0] tdiff;
  logic [31:0] acc_new;

  function automatic bgzf_pkg::result_t verdict_fail(bgzf_pkg::status_e st);
    bgzf_pkg::result_t r;
    r        = '0;
    r.kind   = bgzf_pkg::KIND_VERDICT;
    r.status = st;
    r.last   = 1'b1;
    return r;
  endfunction

  assign in_ready_o = stage_ready;
  assign in_accept  = in_valid_i && stage_ready;

  always_comb begin
    phase_d   = phase_q;
    bp_d      = bp_q;
    span_d    = span_q;
    xl_d      = xl_q;
    sfo_d     = sfo_q;
    sb_d      = sb_q;
    fbs_d     = fbs_q;
    found_d   = found_q;
    acc_d     = acc_q;
    res       = '0;
    res_valid = 1'b0;

    bp_inc  = bp_q + 17'd1;
    xl_new  = {data_byte_i, xl_q[7:0]};
    ext_pos = bp_inc - 17'(bgzf_pkg::HdrLen);
    off17   = {1'b0, sfo_q};
    rel     = ext_pos - off17;
    sb_new  = sb_q | ({24'h0, data_byte_i} << {rel[1:0], 3'b000});
    skip_to = {2'b00, sfo_q} + 18'd4 + {2'b00, sb_new[31:16]};
    bsize   = '0;
    pos18   = {1'b0, bp_inc};
    bs18    = {1'b0, fbs_q};
    tdiff   = pos18 + 18'd4 - bs18;
    acc_new = acc_q | ({24'h0, data_byte_i} << {tdiff[1:0], 3'b000});

    if (block_start_i) begin
      bp_d    = '0;
      xl_d    = '0;
      sfo_d   = '0;
      sb_d    = '0;
      fbs_d   = '0;
      found_d = 1'b0;
      acc_d   = '0;
      span_d  = span_bytes_i;
      if (span_bytes_i < 17'(bgzf_pkg::HdrLen) || data_byte_i != bgzf_pkg::GzipId1) begin
        phase_d   = PH_IDLE;
        res       = verdict_fail(bgzf_pkg::ST_NOTBGZF);
        res_valid = 1'b1;
      end else begin
        phase_d = PH_HEADER;
      end
    end else begin
      case (phase_q)
        PH_IDLE: begin
          phase_d = PH_IDLE;
        end
        PH_HEADER: begin
          bp_d = bp_inc;
          if ((bp_inc == 17'd1 && data_byte_i != bgzf_pkg::GzipId2) ||
              (bp_inc == 17'd3 && !data_byte_i[bgzf_pkg::FextraBit])) begin
            phase_d   = PH_IDLE;
            res       = verdict_fail(bgzf_pkg::ST_NOTBGZF);
            res_valid = 1'b1;
          end else if (bp_inc == 17'd10) begin
            xl_d = {8'h00, data_byte_i};
          end else if (bp_inc == 17'd11) begin
            xl_d = xl_new;
            if (18'(bgzf_pkg::HdrLen) + {2'b00, xl_new} > {1'b0, span_q}) begin
              phase_d   = PH_IDLE;
              res       = verdict_fail(bgzf_pkg::ST_CORRUPT);
              res_valid = 1'b1;
            end else if (xl_new == 16'd0) begin
              // No extra field at all, so no BC subfield can be present.
              phase_d   = PH_IDLE;
              res       = verdict_fail(bgzf_pkg::ST_NOTBGZF);
              res_valid = 1'b1;
            end else begin
              phase_d = PH_EXTRA;
            end
          end
        end
        PH_EXTRA: begin
          bp_d = bp_inc;
          // Only bytes inside a subfield that still fits its four-byte head are looked at.
          if (!(off17 + 17'd4 > {1'b0, xl_q} || ext_pos < off17)) begin
            if (found_q) begin
              if (rel == 17'd4) begin
                fbs_d = {9'h000, data_byte_i};
              end else if (rel == 17'd5) begin
                fbs_d = fbs_q | {1'b0, data_byte_i, 8'h00};
              end
            end else if (rel < 17'd4) begin
              sb_d = sb_new;
              if (rel == 17'd3) begin
                if (sb_new[7:0] == bgzf_pkg::BcSi1 && sb_new[15:8] == bgzf_pkg::BcSi2 &&
                    sb_new[31:16] == bgzf_pkg::BcSlen &&
                    off17 + 17'd6 <= {1'b0, xl_q}) begin
                  found_d = 1'b1;
                end else begin
                  sfo_d = (skip_to > 18'h0FFFF) ? 16'hFFFF : skip_to[15:0];
                  sb_d  = '0;
                end
              end
            end
          end
          if (bp_inc == 17'd11 + {1'b0, xl_q}) begin
            bsize = {1'b0, fbs_d[15:0]} + 17'd1;
            if (!found_d) begin
              phase_d   = PH_IDLE;
              res       = verdict_fail(bgzf_pkg::ST_NOTBGZF);
              res_valid = 1'b1;
            end else begin
              fbs_d = bsize;
              if (bsize > span_q ||
                  {1'b0, bsize} < {2'b00, xl_q} + 18'(bgzf_pkg::Overhead)) begin
                phase_d   = PH_IDLE;
                res       = verdict_fail(bgzf_pkg::ST_CORRUPT);
                res_valid = 1'b1;
              end else begin
                phase_d         = PH_BODY;
                acc_d           = '0;
                res.kind        = bgzf_pkg::KIND_VERDICT;
                res.status      = bgzf_pkg::ST_OK;
                res.block_size  = bsize;
                res.extra_len   = xl_q;
                res.payload_len = bsize - {1'b0, xl_q} - 17'(bgzf_pkg::Overhead);
                res_valid       = 1'b1;
              end
            end
          end
        end
        PH_BODY: begin
          bp_d = bp_inc;
          // The last eight bytes of a block are the CRC and the size word.
          if (pos18 + 18'd8 < bs18) begin
            res.kind         = bgzf_pkg::KIND_PAYLOAD;
            res.payload_byte = data_byte_i;
            res_valid        = 1'b1;
          end else begin
            if (pos18 + 18'd4 >= bs18) begin
              acc_d = acc_new;
            end
            if (pos18 + 18'd1 >= bs18) begin
              phase_d               = PH_IDLE;
              res.kind              = bgzf_pkg::KIND_TRAILER;
              res.uncompressed_size = (pos18 + 18'd4 >= bs18) ? acc_new : acc_q;
              res.last              = 1'b1;
              res_valid             = 1'b1;
            end
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      bp_q    <= '0;
      span_q  <= '0;
      xl_q    <= '0;
      sfo_q   <= '0;
      sb_q    <= '0;
      fbs_q   <= '0;
      found_q <= 1'b0;
      acc_q   <= '0;
    end else if (in_accept) begin
      phase_q <= phase_d;
      bp_q    <= bp_d;
      span_q  <= span_d;
      xl_q    <= xl_d;
      sfo_q   <= sfo_d;
      sb_q    <= sb_d;
      fbs_q   <= fbs_d;
      found_q <= found_d;
      acc_q   <= acc_d;
    end
  end

  bgzf_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_accept && res_valid),
    .res_i       (res),
    .ready_o     (stage_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_out)
  );

  assign kind_o              = res_out.kind;
  assign payload_byte_o      = res_out.payload_byte;
  assign status_o            = res_out.status;
  assign block_size_o        = res_out.block_size;
  assign extra_len_o         = res_out.extra_len;
  assign payload_len_o       = res_out.payload_len;
  assign uncompressed_size_o = res_out.uncompressed_size;
  assign last_o              = res_out.last;

  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && res_valid) |=> out_valid_o)
    else $error("accepted request with a result did not reach the output");

  a_body_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BODY) |-> found_q)
    else $error("body phase entered without a BC subfield");

  a_extra_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_EXTRA) |-> (xl_q != 16'd0))
    else $error("extra phase with an empty extra field");

  a_ok_lengths: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == bgzf_pkg::KIND_VERDICT && status_o == bgzf_pkg::ST_OK) |->
    ({1'b0, payload_len_o} + {2'b00, extra_len_o} + 18'(bgzf_pkg::Overhead) ==
     {1'b0, block_size_o}))
    else $error("ok verdict lengths do not add up");

  a_trailer_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == bgzf_pkg::KIND_TRAILER) |-> last_o)
    else $error("trailer result without last");

endmodule

`default_nettype wire

// ===== bench/tb_bgzf_block_deframer_unit.sv =====
`default_nettype none

module tb_bgzf_block_deframer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumItems    = 1450;
  localparam int unsigned IdlePct     = 27;
  localparam int unsigned QuietLo     = 700;
  localparam int unsigned QuietHi     = 1000;
  localparam int unsigned HoldAt      = 300;
  localparam int unsigned HoldLen     = 250;
  localparam int unsigned PauseAt     = 520;
  localparam int unsigned StallLimit  = 3000;
  localparam int unsigned DrainCycles = 20;
  localparam logic [16:0] SpanMax     = 17'h1FFFF;

  typedef enum logic [1:0] {
    P_IDLE,
    P_HEADER,
    P_EXTRA,
    P_BODY
  } parse_ph_e;

  typedef struct {
    logic [7:0]  data;
    logic        start;
    logic [16:0] span;
  } byte_req_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic [7:0]  data_byte_i   = 8'h00;
  logic        block_start_i = 1'b0;
  logic [16:0] span_bytes_i  = 17'd0;
  logic        out_ready_i   = 1'b0;

  logic        in_ready_o;
  logic        out_valid_o;
  logic [1:0]  kind_o;
  logic [7:0]  payload_byte_o;
  logic [1:0]  status_o;
  logic [16:0] block_size_o;
  logic [15:0] extra_len_o;
  logic [16:0] payload_len_o;
  logic [31:0] uncompressed_size_o;
  logic        last_o;

  bgzf_block_deframer_unit DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .data_byte_i         (data_byte_i),
    .block_start_i       (block_start_i),
    .span_bytes_i        (span_bytes_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .kind_o              (kind_o),
    .payload_byte_o      (payload_byte_o),
    .status_o            (status_o),
    .block_size_o        (block_size_o),
    .extra_len_o         (extra_len_o),
    .payload_len_o       (payload_len_o),
    .uncompressed_size_o (uncompressed_size_o),
    .last_o              (last_o)
  );

  byte_req_t           req_q[$];
  bgzf_pkg::result_t   expected_q[$];
  int unsigned         n_acc;
  int unsigned         n_err;
  int unsigned         hold_left;
  int unsigned         idle_cycles;
  bit                  hold_done;
  bit                  pausing;
  bit                  paused_once;
  bit                  fire_in;
  byte_req_t           nxt_req;
  bgzf_pkg::result_t   res_in;
  bgzf_pkg::result_t   exp_r;

  // Parser state, mirrored from the block's architectural state.
  parse_ph_e   ph;
  logic [16:0] pos;
  logic [16:0] span_q;
  logic [15:0] xlen_q;
  logic [15:0] sf_off;
  logic [31:0] sf_hdr;
  logic [16:0] bc_size;
  logic        bc_seen;
  logic [31:0] isize_acc;

  function automatic void clear_parser();
    ph        = P_IDLE;
    pos       = '0;
    span_q    = '0;
    xlen_q    = '0;
    sf_off    = '0;
    sf_hdr    = '0;
    bc_size   = '0;
    bc_seen   = 1'b0;
    isize_acc = '0;
  endfunction

  function automatic bgzf_pkg::result_t verdict(bgzf_pkg::status_e st);
    bgzf_pkg::result_t r;
    r        = '0;
    r.kind   = bgzf_pkg::KIND_VERDICT;
    r.status = st;
    r.last   = 1'b1;
    ph       = P_IDLE;
    return r;
  endfunction

  function automatic bgzf_pkg::result_t close_extra();
    int unsigned       bs;
    bgzf_pkg::result_t r;
    if (!bc_seen) return verdict(bgzf_pkg::ST_NOTBGZF);
    bs      = 32'(bc_size[15:0]) + 32'd1;
    bc_size = 17'(bs);
    if (bs > 32'(span_q)) return verdict(bgzf_pkg::ST_CORRUPT);
    if (bs < 32'(xlen_q) + bgzf_pkg::Overhead) return verdict(bgzf_pkg::ST_CORRUPT);
    ph            = P_BODY;
    isize_acc     = '0;
    r             = '0;
    r.kind        = bgzf_pkg::KIND_VERDICT;
    r.status      = bgzf_pkg::ST_OK;
    r.block_size  = 17'(bs);
    r.extra_len   = xlen_q;
    r.payload_len = 17'(bs - 32'(xlen_q) - bgzf_pkg::Overhead);
    return r;
  endfunction

  // Advances the parser by one byte; returns 1 when the byte yields a result.
  function automatic bit parse_byte(input logic [7:0] b, input logic start,
                                    input logic [16:0] span,
                                    output bgzf_pkg::result_t r);
    int unsigned e, rr, nxt, off, xl, p, bs, k;
    logic [15:0] slen;
    r = '0;
    if (start) begin
      clear_parser();
      span_q = span;
      if (32'(span) < bgzf_pkg::HdrLen || b != bgzf_pkg::GzipId1) begin
        r = verdict(bgzf_pkg::ST_NOTBGZF);
        return 1'b1;
      end
      ph = P_HEADER;
      return 1'b0;
    end
    if (ph == P_IDLE) return 1'b0;
    pos = pos + 17'd1;
    p   = 32'(pos);
    off = 32'(sf_off);
    xl  = 32'(xlen_q);
    case (ph)
      P_HEADER: begin
        if ((p == 1 && b != bgzf_pkg::GzipId2) || (p == 3 && !b[bgzf_pkg::FextraBit])) begin
          r = verdict(bgzf_pkg::ST_NOTBGZF);
          return 1'b1;
        end
        if (p == 10) xlen_q = {8'h00, b};
        if (p == 11) begin
          xlen_q[15:8] = b;
          if (bgzf_pkg::HdrLen + 32'(xlen_q) > 32'(span_q)) begin
            r = verdict(bgzf_pkg::ST_CORRUPT);
            return 1'b1;
          end
          if (xlen_q == 16'd0) begin
            r = close_extra();
            return 1'b1;
          end
          ph = P_EXTRA;
        end
        return 1'b0;
      end
      P_EXTRA: begin
        e = p - bgzf_pkg::HdrLen;
        if (off + 32'd4 <= xl && e >= off) begin
          rr = e - off;
          if (bc_seen) begin
            // The two data bytes of BC follow its four-byte subfield header.
            if (rr == 4) bc_size = {9'h000, b};
            else if (rr == 5) bc_size = bc_size | {1'b0, b, 8'h00};
          end else if (rr < 4) begin
            sf_hdr = sf_hdr | (32'(b) << (8 * rr));
            if (rr == 3) begin
              slen = sf_hdr[31:16];
              if (sf_hdr[7:0] == bgzf_pkg::BcSi1 && sf_hdr[15:8] == bgzf_pkg::BcSi2 &&
                  slen == bgzf_pkg::BcSlen && off + 32'd6 <= xl) begin
                bc_seen = 1'b1;
              end else begin
                nxt    = off + 32'd4 + 32'(slen);
                sf_off = (nxt > 32'hFFFF) ? 16'hFFFF : nxt[15:0];
                sf_hdr = '0;
              end
            end
          end
        end
        if (p == bgzf_pkg::HdrLen - 1 + xl) begin
          r = close_extra();
          return 1'b1;
        end
        return 1'b0;
      end
      P_BODY: begin
        bs = 32'(bc_size);
        if (p + 8 < bs) begin
          r.kind         = bgzf_pkg::KIND_PAYLOAD;
          r.payload_byte = b;
          return 1'b1;
        end
        if (p + 4 >= bs) begin
          k         = (p + 4 - bs) & 32'd3;
          isize_acc = isize_acc | (32'(b) << (8 * k));
        end
        if (p + 1 >= bs) begin
          ph                  = P_IDLE;
          r.kind              = bgzf_pkg::KIND_TRAILER;
          r.uncompressed_size = isize_acc;
          r.last              = 1'b1;
          return 1'b1;
        end
        return 1'b0;
      end
      default: begin
        ph = P_IDLE;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic void push_byte(logic [7:0] d, logic s, logic [16:0] sp);
    req_q.push_back('{d, s, sp});
  endfunction

  // Builds one block candidate: mostly well-formed BGZF blocks, with a share
  // of damaged headers, broken extra fields, bad sizes and cut-off blocks.
  function automatic void queue_block();
    logic [7:0]  ex[$];
    logic [7:0]  blk[$];
    int unsigned mode, n_sf, bc_idx, bc_at, sl, plen, total, bc_val, span, keep, k;
    bit          has_bc;
    logic [15:0] xlen_f;
    mode   = $urandom_range(0, 99);
    n_sf   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    bc_idx = $urandom_range(0, n_sf);
    bc_at  = 0;
    has_bc = 1'b1;
    for (int i = 0; i <= int'(n_sf); i++) begin
      if (i == int'(bc_idx)) begin
        bc_at = ex.size();
        ex.push_back(bgzf_pkg::BcSi1);
        ex.push_back(bgzf_pkg::BcSi2);
        ex.push_back(bgzf_pkg::BcSlen[7:0]);
        ex.push_back(bgzf_pkg::BcSlen[15:8]);
        ex.push_back(8'h00);
        ex.push_back(8'h00);
      end
      if (i < int'(n_sf)) begin
        sl = $urandom_range(0, 4);
        ex.push_back(8'($urandom));
        ex.push_back(8'($urandom));
        ex.push_back(8'(sl));
        ex.push_back(8'h00);
        repeat (sl) ex.push_back(8'($urandom));
      end
    end

    if (mode >= 54 && mode <= 59) begin
      repeat (6) ex.delete(bc_at);
      has_bc = 1'b0;
    end else if (mode >= 60 && mode <= 65) begin
      ex[bc_at + 2] = ($urandom_range(0, 1) == 0) ? 8'd1 : 8'($urandom_range(3, 255));
      ex[bc_at + 3] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00;
    end else if (mode >= 66 && mode <= 71) begin
      // BC header present but its data would run past the extra field.
      k = $urandom_range(0, 1);
      while (ex.size() > bc_at + 4 + k) ex.pop_back();
    end else if (mode >= 90 && mode <= 93) begin
      // A huge subfield length pushes the walk offset to its ceiling.
      ex.delete();
      ex.push_back(8'($urandom));
      ex.push_back(8'($urandom));
      ex.push_back(8'($urandom_range(252, 255)));
      ex.push_back(8'hFF);
      repeat ($urandom_range(0, 3)) ex.push_back(8'($urandom));
      has_bc = 1'b0;
    end

    k      = $urandom_range(0, 19);
    plen   = (k < 17) ? $urandom_range(0, 16) :
             (k < 19) ? $urandom_range(17, 64) : $urandom_range(65, 300);
    total  = bgzf_pkg::HdrLen + ex.size() + plen + 8;
    bc_val = total - 1;
    span   = total + $urandom_range(0, 3);
    xlen_f = 16'(ex.size());
    if (mode >= 35 && mode <= 39) begin
      bc_val = 32'hFFFF;
      span   = $urandom_range(65536, 131071);
    end else if (mode >= 40 && mode <= 46) begin
      bc_val = $urandom_range(0, ex.size() + 18);
    end else if (mode >= 47 && mode <= 53) begin
      span = $urandom_range(bgzf_pkg::HdrLen, total - 1);
    end else if (mode >= 86 && mode <= 89) begin
      xlen_f = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'($urandom_range(total, 65534));
    end else if (mode >= 94 && mode <= 96) begin
      span = $urandom_range(0, bgzf_pkg::HdrLen - 1);
    end else if (mode >= 97) begin
      span = 32'(SpanMax);
    end
    if (has_bc && bc_at + 4 < ex.size()) ex[bc_at + 4] = bc_val[7:0];
    if (has_bc && bc_at + 5 < ex.size()) ex[bc_at + 5] = bc_val[15:8];

    blk.push_back(bgzf_pkg::GzipId1);
    blk.push_back(bgzf_pkg::GzipId2);
    blk.push_back(8'd8);
    blk.push_back(8'($urandom) | 8'h04);
    repeat (6) blk.push_back(8'($urandom));
    blk.push_back(xlen_f[7:0]);
    blk.push_back(xlen_f[15:8]);
    foreach (ex[i]) blk.push_back(ex[i]);
    repeat (plen + 4) blk.push_back(8'($urandom));
    k = $urandom_range(0, 3);
    repeat (4) blk.push_back((k == 0) ? 8'hFF : (k == 1) ? 8'h00 : 8'($urandom));

    keep = blk.size();
    if (mode >= 72 && mode <= 79) begin
      k = $urandom_range(0, 2);
      if (k == 0) blk[0] = blk[0] ^ 8'($urandom_range(1, 255));
      else if (k == 1) blk[1] = blk[1] ^ 8'($urandom_range(1, 255));
      else blk[3] = blk[3] & 8'hFB;
      keep = ((k == 2) ? 4 : k + 1) + $urandom_range(0, 2);
    end else if (mode >= 80 && mode <= 85) begin
      keep = $urandom_range(2, blk.size() - 1);
    end else if (mode >= 86 && mode <= 89) begin
      keep = bgzf_pkg::HdrLen + $urandom_range(0, 2);
    end else if (mode >= 94 && mode <= 96) begin
      keep = 1 + $urandom_range(0, 2);
    end
    foreach (blk[i])
      if (i < int'(keep)) push_byte(blk[i], i == 0, (i == 0) ? 17'(span) : 17'($urandom));
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 6)) push_byte(8'($urandom), 1'b0, 17'($urandom));
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      n_err++;
    end
  endfunction

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Request driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      fire_in = in_valid_i && in_ready_o;
      if (fire_in) begin
        if (parse_byte(data_byte_i, block_start_i, span_bytes_i, res_in))
          expected_q.push_back(res_in);
        n_acc++;
        if (n_acc == PauseAt && !paused_once) begin
          pausing     = 1'b1;
          paused_once = 1'b1;
        end
      end
      if (pausing && expected_q.size() == 0) pausing = 1'b0;
      if (!in_valid_i || fire_in) begin
        if (req_q.size() != 0 && !pausing &&
            ((n_acc >= QuietLo && n_acc < QuietHi) || $urandom_range(0, 99) >= IdlePct)) begin
          nxt_req       = req_q.pop_front();
          in_valid_i    <= 1'b1;
          data_byte_i   <= nxt_req.data;
          block_start_i <= nxt_req.start;
          span_bytes_i  <= nxt_req.span;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor; it also holds the sink off once for a long stretch.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual kind %0d status %0d",
                   $time, kind_o, status_o);
          n_err++;
        end else begin
          exp_r = expected_q.pop_front();
          check_field("kind", 32'(exp_r.kind), 32'(kind_o));
          check_field("payload_byte", 32'(exp_r.payload_byte), 32'(payload_byte_o));
          check_field("status", 32'(exp_r.status), 32'(status_o));
          check_field("block_size", 32'(exp_r.block_size), 32'(block_size_o));
          check_field("extra_len", 32'(exp_r.extra_len), 32'(extra_len_o));
          check_field("payload_len", 32'(exp_r.payload_len), 32'(payload_len_o));
          check_field("uncompressed_size", exp_r.uncompressed_size, uncompressed_size_o);
          check_field("last", 32'(exp_r.last), 32'(last_o));
        end
      end
      if (!hold_done && n_acc >= HoldAt) begin
        hold_done = 1'b1;
        hold_left = HoldLen;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= (n_acc >= QuietLo && n_acc < QuietHi) ||
                       ($urandom_range(0, 99) >= IdlePct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("%0t: timeout, no request moved for %0d cycles", $time, StallLimit);
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    clear_parser();
    n_acc       = 0;
    n_err       = 0;
    hold_left   = 0;
    hold_done   = 1'b0;
    pausing     = 1'b0;
    paused_once = 1'b0;
    idle_cycles = 0;

    // A stray byte while idle, then headers that fail early.
    push_byte(8'hFF, 1'b0, SpanMax);
    push_byte(bgzf_pkg::GzipId1, 1'b1, 17'd0);
    push_byte(bgzf_pkg::GzipId1, 1'b1, 17'(bgzf_pkg::HdrLen - 1));
    push_byte(8'h00, 1'b1, 17'(bgzf_pkg::HdrLen));
    push_byte(bgzf_pkg::GzipId1, 1'b1, SpanMax);
    push_byte(8'h8A, 1'b0, 17'd0);
    push_byte(bgzf_pkg::GzipId1, 1'b1, 17'd100);
    push_byte(bgzf_pkg::GzipId2, 1'b0, 17'd0);
    push_byte(8'd8, 1'b0, 17'd0);
    push_byte(8'hFB, 1'b0, 17'd0);
    push_byte(8'hFF, 1'b0, SpanMax);
    // An empty extra field in a span that just holds the header.
    push_byte(bgzf_pkg::GzipId1, 1'b1, 17'(bgzf_pkg::HdrLen));
    push_byte(bgzf_pkg::GzipId2, 1'b0, 17'd0);
    push_byte(8'd8, 1'b0, 17'd0);
    push_byte(8'h04, 1'b0, 17'd0);
    repeat (6) push_byte(8'hFF, 1'b0, SpanMax);
    push_byte(8'h00, 1'b0, 17'd0);
    push_byte(8'h00, 1'b0, 17'd0);

    while (req_q.size() < NumItems) queue_block();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (req_q.size() != 0 || in_valid_i || expected_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (n_err == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire
